/* sv/block_cipher_1024_bit_defines.svh */
// Assertion macros used by the top file of the cipher block.
`ifndef BLOCK_CIPHER_1024_BIT_DEFINES_SVH
`define BLOCK_CIPHER_1024_BIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bc_pkg.sv */
// ----------------------------------------------------------------------------
// bc_pkg
// Types, constants and small helper functions of the 1024-bit block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package bc_pkg;

    localparam int BLK_AW   = 5;   // two banks of sixteen words
    localparam int ROUND_W  = 4;   // holds round numbers up to fifteen
    localparam int CNT_W    = 3;
    localparam int IDX_W    = 3;   // configuration register index

    localparam logic [CNT_W-1:0] NEWTON_LAST = 3'd5;  // six steps in all

    localparam logic [IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;

    localparam logic [63:0] MIX_MASK = 64'h5555555555555555;
    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;

    localparam logic [63:0] SCHED_CONST [12] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd,
        64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf148e141, 64'h59f111f11b6028c1,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe,
        64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2
    };

    localparam logic [63:0] ROUND_CONST [12] = '{
        64'h243F6A8885A308D3, 64'h13198A2E03707344,
        64'hA4093822299F31D0, 64'h082EFA98EC4E6C89,
        64'h452821E638D01377, 64'hBE5466CF34E90C6C,
        64'hCAC70C47B2C20958, 64'h818C0C0B5C268847,
        64'hADD6A2D48DE515AA, 64'h09B6B8D3A7FD6196,
        64'h5FA5B1E3D5A6E5C4, 64'h72B8E64A3CF1E8F3
    };

    typedef enum logic [4:0] {
        C_IDLE, C_LDK, C_INVW, C_INVW_NX,
        C_EA_RD, C_EA_X, C_EA_W,
        C_B_RD, C_B_X, C_B_W,
        C_DA_RD, C_DA_X, C_U_SQ, C_U_SQW, C_U_DM, C_U_DMW, C_DA_FIN,
        C_I_M1, C_I_W1, C_I_M2, C_I_W2,
        C_OUT
    } t_cstate;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_T, S_A, S_B, S_WR
    } t_sstate;

    typedef struct packed {
        logic              we;
        logic [BLK_AW-1:0] waddr;
        logic [63:0]       wdata;
        logic [BLK_AW-1:0] raddr;
    } t_bram_req;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] n);
        logic [127:0] t;
        t = {v, v} << n;
        return t[127:64];
    endfunction

    function automatic logic [5:0] rot_amt(input logic [3:0] i,
                                           input logic [ROUND_W-1:0] r);
        logic [5:0] a;
        a = {1'b0, i, 1'b1} + ({2'b00, r} * 6'd7);
        return a;
    endfunction

    function automatic logic [3:0] perm7(input logic [3:0] i);
        logic [7:0] m;
        m = {4'b0000, i} * 8'd7;
        return m[3:0];
    endfunction

endpackage

`default_nettype wire

/* sv/bc_ram.sv */
// ----------------------------------------------------------------------------
// bc_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/bc_mul.sv */
// ----------------------------------------------------------------------------
// bc_mul
// Low 64 bits of a 64 by 64 product, built from three 32 by 32 partial
// products on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic      [63:0] o_p
);

    logic [63:0] r_a, r_b, r_acc;
    logic [2:0]  r_ph;
    logic        r_done;
    logic [31:0] ma, mb;
    logic [63:0] pp;

    always_comb begin
        ma = r_a[31:0];
        mb = r_b[31:0];
        if (r_ph[1]) begin
            mb = r_b[63:32];
        end
        if (r_ph[2]) begin
            ma = r_a[63:32];
        end
        pp = {32'd0, ma} * {32'd0, mb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= '0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= {r_ph[1:0], i_start && (r_ph == '0)};
            r_done <= r_ph[2];
        end
        if (i_start && (r_ph == '0)) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_ph[0]) begin
            r_acc <= pp;
        end else if (r_ph[1] || r_ph[2]) begin
            r_acc[63:32] <= r_acc[63:32] + pp[31:0];
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

`default_nettype wire

/* sv/bc_core.sv */
// ----------------------------------------------------------------------------
// bc_core
// Gathers the words of a block, runs the rounds by read-modify-write on the
// block memory, and reads the finished block out.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_core #(
    parameter int ROUND_COUNT = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic                                 i_mode,
    input  wire logic [63:0]                          i_data_word,
    output logic                                      o_busy,
    output logic [$clog2(4*ROUND_COUNT)-1:0]          o_kaddr,
    input  wire logic [63:0]                          i_kdata,
    output bc_pkg::t_bram_req                         o_breq,
    input  wire logic [63:0]                          i_brdata,
    output logic                                      o_valid,
    output logic                                      o_last
);

    localparam int KA_W = $clog2(4*ROUND_COUNT);
    localparam logic [bc_pkg::ROUND_W-1:0] RND_LAST = bc_pkg::ROUND_W'(ROUND_COUNT - 1);

    bc_pkg::t_cstate r_state, n_state, r_ret;

    logic                       r_bank, r_mode, r_valid, r_last_o;
    logic [3:0]                 r_pos, r_i;
    logic [bc_pkg::ROUND_W-1:0] r_rnd;
    logic [1:0]                 r_j, r_k;
    logic [2:0]                 r_kc;
    logic [bc_pkg::CNT_W-1:0]   r_in, r_un;
    logic [63:0]                r_rk [4];
    logic [63:0]                r_w  [4];
    logic [63:0]                r_prev, r_y, r_z, r_last, r_acc, r_diff;
    logic [63:0]                r_inv_a, r_inv_x, r_inv_t;

    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;

    logic [1:0]  rk_idx;
    logic [63:0] rk_sel, x_sum, rot_prev, ea_y, sq_v, enc_v, enc_out;
    logic [3:0]  col_src, col_dst;
    logic [63:0] col_pre, acc_eff, col_out, dec_v, fin_t, fin_out;

    bc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // Datapath values of the states.
    always_comb begin
        rk_idx   = (r_state == bc_pkg::C_INVW) ? r_j : r_i[1:0];
        rk_sel   = r_rk[rk_idx];
        x_sum    = i_brdata + rk_sel;
        rot_prev = bc_pkg::rotl64(r_prev, bc_pkg::rot_amt(r_i, r_rnd));
        ea_y     = (r_i == 4'd0) ? x_sum : (x_sum ^ rot_prev);
        sq_v     = r_y + (mul_p | 64'd1);
        enc_v    = sq_v ^ bc_pkg::ROUND_CONST[r_rnd];
        enc_out  = enc_v ^ ((enc_v >> 1) & bc_pkg::MIX_MASK);
        col_src  = r_mode ? bc_pkg::perm7({r_j, r_k}) : {r_j, r_k};
        col_dst  = r_mode ? {r_j, r_k} : bc_pkg::perm7({r_j, r_k});
        if (&r_k) begin
            col_pre = i_brdata;
        end else if (r_mode) begin
            col_pre = i_brdata - r_last;
        end else begin
            col_pre = i_brdata + r_last;
        end
        acc_eff  = (&r_k) ? 64'd0 : r_acc;
        col_out  = r_mode ? (mul_p - acc_eff) : (mul_p + acc_eff);
        dec_v    = i_brdata ^ ((i_brdata >> 1) & bc_pkg::MIX_MASK)
                   ^ bc_pkg::ROUND_CONST[r_rnd];
        fin_t    = (r_i == 4'd0) ? r_y : (r_y ^ rot_prev);
        fin_out  = fin_t - rk_sel;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bc_pkg::C_IDLE: begin
                if (i_start && (&r_pos)) begin
                    n_state = bc_pkg::C_LDK;
                end
            end
            bc_pkg::C_LDK: begin
                if (r_kc[2]) begin
                    n_state = r_mode ? bc_pkg::C_INVW : bc_pkg::C_EA_RD;
                end
            end
            bc_pkg::C_INVW:    n_state = bc_pkg::C_I_M1;
            bc_pkg::C_INVW_NX: n_state = (&r_j) ? bc_pkg::C_B_RD : bc_pkg::C_INVW;
            bc_pkg::C_EA_RD:   n_state = bc_pkg::C_EA_X;
            bc_pkg::C_EA_X:    n_state = bc_pkg::C_EA_W;
            bc_pkg::C_EA_W: begin
                if (mul_done) begin
                    n_state = (&r_i) ? bc_pkg::C_B_RD : bc_pkg::C_EA_RD;
                end
            end
            bc_pkg::C_B_RD: n_state = bc_pkg::C_B_X;
            bc_pkg::C_B_X:  n_state = bc_pkg::C_B_W;
            bc_pkg::C_B_W: begin
                if (mul_done) begin
                    if ((r_k == 2'd0) && (&r_j)) begin
                        if (r_mode) begin
                            n_state = bc_pkg::C_DA_RD;
                        end else if (r_rnd == RND_LAST) begin
                            n_state = bc_pkg::C_OUT;
                        end else begin
                            n_state = bc_pkg::C_LDK;
                        end
                    end else begin
                        n_state = bc_pkg::C_B_RD;
                    end
                end
            end
            bc_pkg::C_DA_RD: n_state = bc_pkg::C_DA_X;
            bc_pkg::C_DA_X:  n_state = bc_pkg::C_U_SQ;
            bc_pkg::C_U_SQ:  n_state = bc_pkg::C_U_SQW;
            bc_pkg::C_U_SQW: begin
                if (mul_done) begin
                    n_state = bc_pkg::C_I_M1;
                end
            end
            bc_pkg::C_U_DM: n_state = bc_pkg::C_U_DMW;
            bc_pkg::C_U_DMW: begin
                if (mul_done) begin
                    n_state = (r_un == bc_pkg::NEWTON_LAST) ? bc_pkg::C_DA_FIN
                                                             : bc_pkg::C_U_SQ;
                end
            end
            bc_pkg::C_DA_FIN: begin
                if (&r_i) begin
                    n_state = (r_rnd == '0) ? bc_pkg::C_OUT : bc_pkg::C_LDK;
                end else begin
                    n_state = bc_pkg::C_DA_RD;
                end
            end
            bc_pkg::C_I_M1: n_state = bc_pkg::C_I_W1;
            bc_pkg::C_I_W1: begin
                if (mul_done) begin
                    n_state = bc_pkg::C_I_M2;
                end
            end
            bc_pkg::C_I_M2: n_state = bc_pkg::C_I_W2;
            bc_pkg::C_I_W2: begin
                if (mul_done) begin
                    n_state = (r_in == bc_pkg::NEWTON_LAST) ? r_ret : bc_pkg::C_I_M1;
                end
            end
            bc_pkg::C_OUT: begin
                if (&r_i) begin
                    n_state = bc_pkg::C_IDLE;
                end
            end
            default: n_state = bc_pkg::C_IDLE;
        endcase
    end

    // Memory and multiplier controls.
    always_comb begin
        o_breq.we    = 1'b0;
        o_breq.waddr = {r_bank, r_i};
        o_breq.wdata = enc_out;
        o_breq.raddr = {r_bank, r_i};
        o_kaddr      = KA_W'({r_rnd, r_kc[1:0]});
        mul_start    = 1'b0;
        mul_a        = r_inv_a;
        mul_b        = r_inv_x;
        case (r_state)
            bc_pkg::C_IDLE: begin
                o_breq.we    = i_start;
                o_breq.waddr = {r_bank, r_pos};
                o_breq.wdata = i_data_word;
            end
            bc_pkg::C_EA_X: begin
                mul_start = 1'b1;
                mul_a     = ea_y;
                mul_b     = ea_y;
            end
            bc_pkg::C_EA_W: begin
                o_breq.we = mul_done;
            end
            bc_pkg::C_B_RD: begin
                o_breq.raddr = {r_bank, col_src};
            end
            bc_pkg::C_B_X: begin
                mul_start = 1'b1;
                mul_a     = col_pre;
                mul_b     = r_w[r_k];
            end
            bc_pkg::C_B_W: begin
                o_breq.we    = mul_done;
                o_breq.waddr = {~r_bank, col_dst};
                o_breq.wdata = col_out;
            end
            bc_pkg::C_U_SQ: begin
                mul_start = 1'b1;
                mul_a     = r_y;
                mul_b     = r_y;
            end
            bc_pkg::C_U_DM: begin
                mul_start = 1'b1;
                mul_a     = r_diff;
                mul_b     = r_inv_x;
            end
            bc_pkg::C_DA_FIN: begin
                o_breq.we    = 1'b1;
                o_breq.wdata = fin_out;
            end
            bc_pkg::C_I_M1: begin
                mul_start = 1'b1;
            end
            bc_pkg::C_I_M2: begin
                mul_start = 1'b1;
                mul_a     = r_inv_x;
                mul_b     = r_inv_t;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bc_pkg::C_IDLE;
            r_bank   <= 1'b0;
            r_pos    <= '0;
            r_valid  <= 1'b0;
            r_last_o <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= (r_state == bc_pkg::C_OUT);
            r_last_o <= (r_state == bc_pkg::C_OUT) && (&r_i);
            if ((r_state == bc_pkg::C_IDLE) && i_start) begin
                r_pos <= r_pos + 4'd1;
            end
            if ((r_state == bc_pkg::C_B_W) && mul_done && (r_k == 2'd0) && (&r_j)) begin
                r_bank <= ~r_bank;
            end
        end

        case (r_state)
            bc_pkg::C_IDLE: begin
                r_kc <= '0;
                r_i  <= '0;
                r_j  <= '0;
                r_k  <= '1;
                if (i_start && (&r_pos)) begin
                    r_mode <= i_mode;
                    r_rnd  <= i_mode ? RND_LAST : '0;
                end
            end
            bc_pkg::C_LDK: begin
                r_kc <= r_kc + 3'd1;
                if (r_kc != 3'd0) begin
                    r_rk[2'(r_kc - 3'd1)] <= i_kdata;
                    r_w[2'(r_kc - 3'd1)]  <= i_kdata | 64'd1;
                end
                r_i <= '0;
                r_j <= '0;
                r_k <= '1;
            end
            bc_pkg::C_INVW: begin
                r_inv_a <= rk_sel | 64'd1;
                r_inv_x <= rk_sel | 64'd1;
                r_in    <= '0;
                r_ret   <= bc_pkg::C_INVW_NX;
            end
            bc_pkg::C_INVW_NX: begin
                r_w[r_j] <= r_inv_x;
                r_j      <= r_j + 2'd1;
            end
            bc_pkg::C_EA_X: begin
                r_prev <= x_sum;
                r_y    <= ea_y;
            end
            bc_pkg::C_EA_W: begin
                if (mul_done) begin
                    r_i <= r_i + 4'd1;
                end
            end
            bc_pkg::C_B_X: begin
                r_last <= i_brdata;
            end
            bc_pkg::C_B_W: begin
                if (mul_done) begin
                    r_acc <= col_out;
                    r_k   <= r_k - 2'd1;
                    if (r_k == 2'd0) begin
                        r_j <= r_j + 2'd1;
                        if (&r_j) begin
                            r_i  <= '0;
                            r_kc <= '0;
                            if (!r_mode) begin
                                r_rnd <= r_rnd + 1'b1;
                            end
                        end
                    end
                end
            end
            bc_pkg::C_DA_X: begin
                r_z  <= dec_v;
                r_y  <= dec_v ^ 64'd1;
                r_un <= '0;
            end
            bc_pkg::C_U_SQW: begin
                if (mul_done) begin
                    r_diff  <= sq_v - r_z;
                    r_inv_a <= {r_y[62:0], 1'b1};
                    r_inv_x <= {r_y[62:0], 1'b1};
                    r_in    <= '0;
                    r_ret   <= bc_pkg::C_U_DM;
                end
            end
            bc_pkg::C_U_DMW: begin
                if (mul_done) begin
                    r_y  <= r_y - mul_p;
                    r_un <= r_un + 1'b1;
                end
            end
            bc_pkg::C_DA_FIN: begin
                r_prev <= fin_t;
                r_i    <= r_i + 4'd1;
                r_kc   <= '0;
                if ((&r_i) && (r_rnd != '0)) begin
                    r_rnd <= r_rnd - 1'b1;
                end
            end
            bc_pkg::C_I_W1: begin
                if (mul_done) begin
                    r_inv_t <= 64'd2 - mul_p;
                end
            end
            bc_pkg::C_I_W2: begin
                if (mul_done) begin
                    r_inv_x <= mul_p;
                    r_in    <= r_in + 1'b1;
                end
            end
            bc_pkg::C_OUT: begin
                r_i <= r_i + 4'd1;
            end
            default: begin
                r_kc <= r_kc;
            end
        endcase
    end

    assign o_busy  = (r_state != bc_pkg::C_IDLE);
    assign o_valid = r_valid;
    assign o_last  = r_last_o;

endmodule

`default_nettype wire

/* sv/block_cipher_1024_bit.sv */
// ----------------------------------------------------------------------------
// block_cipher_1024_bit
// 1024-bit block cipher taking and giving one 64-bit word at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "block_cipher_1024_bit_defines.svh"

// A block is sixteen 64-bit words, word 0 first. A word is taken at each
// rising edge where start is high and busy is low; the mode bit of the
// sixteenth word chooses encryption (0) or decryption (1) for the whole
// block. Busy then stays high while the rounds run, and the sixteen result
// words come out on consecutive cycles, each marked by o_result_valid
// for one cycle, the last one also by o_last_word. The receiver cannot
// stall the output, so it must take every word as it comes.
// All rounds work in place on a two-bank block memory, one word at a time,
// with a single shared 64-bit multiplier built from one 32 by 32 multiplier;
// that multiplier sets the pace. Decryption spends most of its time in the
// Newton inversion of the round polynomial, sixteen words times six steps,
// each with its own modular inverse. Gathering and reading out take the
// words one at a time. The four key registers are written through the
// configuration channel with index 0 to 3; other indices are ignored.
// o_cfg_ready is low while a block is being processed or read out and
// while start is high, so a key write never lands on a block in flight.
// After reset and after each key write, the round keys are rebuilt into
// the key memory, during which o_cfg_ready is low and busy is held high.

module block_cipher_1024_bit #(
    parameter int ROUND_COUNT = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_mode,
    input  wire logic [63:0]               i_data_word,
    output logic                           o_result_valid,
    output logic      [63:0]               o_result_word,
    output logic                           o_last_word,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [bc_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [63:0]               i_cfg_data
);

    localparam int KA_W = $clog2(4*ROUND_COUNT);
    localparam logic [bc_pkg::ROUND_W-1:0] RND_LAST = bc_pkg::ROUND_W'(ROUND_COUNT - 1);

    // Master key and the key schedule's working words.
    logic [63:0]                r_key [4];
    logic [63:0]                r_sk  [4];
    logic [63:0]                r_st;
    logic [bc_pkg::ROUND_W-1:0] r_srnd;
    logic [1:0]                 r_swc;
    bc_pkg::t_sstate            r_sst, n_sst;

    logic                       cfg_acc, core_busy, core_start;
    logic [63:0]                s_p, s_t, s_k0, s_k2, s_wdata;
    logic [KA_W-1:0]            kwaddr, kraddr;
    logic [63:0]                kdata, brdata;
    bc_pkg::t_bram_req          breq;

    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = (r_sst == bc_pkg::S_IDLE) && !core_busy && !start;
    assign busy        = core_busy || (r_sst != bc_pkg::S_IDLE);
    assign core_start  = start && !busy;

    // One schedule round is split over the states S_T, S_A and S_B so that
    // no more than two adds stand in series.
    always_comb begin
        s_p    = r_sk[0] + bc_pkg::SCHED_CONST[r_srnd];
        s_t    = (s_p ^ bc_pkg::rotl64(s_p, 6'd29)) + bc_pkg::GOLDEN;
        s_k0   = r_sk[0] + r_st;
        s_k2   = r_sk[2] + r_sk[1];
        kwaddr = KA_W'({r_srnd, r_swc});
        case (r_swc)
            2'd0:    s_wdata = r_sk[1];
            2'd1:    s_wdata = r_sk[2];
            2'd2:    s_wdata = r_sk[3];
            default: s_wdata = r_sk[0];
        endcase
    end

    always_comb begin
        n_sst = r_sst;
        case (r_sst)
            bc_pkg::S_IDLE: begin
                if (cfg_acc) begin
                    case (i_cfg_index)
                        bc_pkg::REG_KEY_WORD_0,
                        bc_pkg::REG_KEY_WORD_1,
                        bc_pkg::REG_KEY_WORD_2,
                        bc_pkg::REG_KEY_WORD_3: n_sst = bc_pkg::S_LOAD;
                        default:                n_sst = bc_pkg::S_IDLE;
                    endcase
                end
            end
            bc_pkg::S_LOAD: n_sst = bc_pkg::S_T;
            bc_pkg::S_T:    n_sst = bc_pkg::S_A;
            bc_pkg::S_A:    n_sst = bc_pkg::S_B;
            bc_pkg::S_B:    n_sst = bc_pkg::S_WR;
            bc_pkg::S_WR: begin
                if (&r_swc) begin
                    n_sst = (r_srnd == RND_LAST) ? bc_pkg::S_IDLE : bc_pkg::S_T;
                end
            end
            default: n_sst = bc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sst    <= bc_pkg::S_LOAD;
            r_key[0] <= '0;
            r_key[1] <= '0;
            r_key[2] <= '0;
            r_key[3] <= '0;
        end else begin
            r_sst <= n_sst;
            if (cfg_acc) begin
                case (i_cfg_index)
                    bc_pkg::REG_KEY_WORD_0: r_key[0] <= i_cfg_data;
                    bc_pkg::REG_KEY_WORD_1: r_key[1] <= i_cfg_data;
                    bc_pkg::REG_KEY_WORD_2: r_key[2] <= i_cfg_data;
                    bc_pkg::REG_KEY_WORD_3: r_key[3] <= i_cfg_data;
                    default:                r_key[0] <= r_key[0];
                endcase
            end
        end

        case (r_sst)
            bc_pkg::S_LOAD: begin
                r_sk   <= r_key;
                r_srnd <= '0;
            end
            bc_pkg::S_T: begin
                r_st <= s_t;
            end
            bc_pkg::S_A: begin
                r_sk[0] <= s_k0;
                r_sk[1] <= r_sk[1] ^ s_k0;
            end
            bc_pkg::S_B: begin
                r_sk[2] <= s_k2;
                r_sk[3] <= r_sk[3] ^ s_k2;
                r_swc   <= '0;
            end
            bc_pkg::S_WR: begin
                r_swc <= r_swc + 2'd1;
                if (&r_swc) begin
                    // Word rotation at the end of each schedule round.
                    r_sk[0] <= r_sk[1];
                    r_sk[1] <= r_sk[2];
                    r_sk[2] <= r_sk[3];
                    r_sk[3] <= r_sk[0];
                    r_srnd  <= r_srnd + 1'b1;
                end
            end
            default: begin
                r_st <= r_st;
            end
        endcase
    end

    // Round keys, four words per round.
    bc_ram #(
        .WIDTH (64),
        .DEPTH (4*ROUND_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (r_sst == bc_pkg::S_WR),
        .i_waddr (kwaddr),
        .i_wdata (s_wdata),
        .i_raddr (kraddr),
        .o_rdata (kdata)
    );

    // Block store: two banks of sixteen words, swapped by each word permutation.
    bc_ram #(
        .WIDTH (64),
        .DEPTH (32)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (breq.we),
        .i_waddr (breq.waddr),
        .i_wdata (breq.wdata),
        .i_raddr (breq.raddr),
        .o_rdata (brdata)
    );

    bc_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (core_start),
        .i_mode      (i_mode),
        .i_data_word (i_data_word),
        .o_busy      (core_busy),
        .o_kaddr     (kraddr),
        .i_kdata     (kdata),
        .o_breq      (breq),
        .i_brdata    (brdata),
        .o_valid     (o_result_valid),
        .o_last      (o_last_word)
    );

    // The read data of the block memory is already registered.
    assign o_result_word = brdata;

    `BC_ASSERT_NEXT(a_last_ends_burst, i_clk, i_rst_n, o_last_word, !o_result_valid, "word after last")
    `BC_ASSERT_NEXT(a_burst_unbroken, i_clk, i_rst_n, o_result_valid && !o_last_word, o_result_valid, "gap in result burst")
    `BC_ASSERT_SAME(a_result_after_busy, i_clk, i_rst_n, o_result_valid, $past(busy), "result word without busy")

endmodule

`default_nettype wire
